FILE: rtl/core/jdm_pkg.sv
package jdm_pkg;

  localparam logic [1:0] CMD_PACKET = 2'd0;
  localparam logic [1:0] CMD_POLL   = 2'd1;
  localparam logic [1:0] CMD_SERIAL = 2'd2;

  localparam logic REG_LOSS_THRESHOLD = 1'b0;
  localparam logic REG_LOSS_RELOAD    = 1'b1;

  localparam logic [7:0] LOSS_THRESHOLD_RESET = 8'd11;
  localparam logic [7:0] LOSS_RELOAD_RESET    = 8'd10;

  localparam logic [7:0] DUTY_MAX      = 8'd13;
  localparam logic [7:0] TURN_LEFT_MIN = 8'd19;
  localparam logic [7:0] SPEED_CAP     = 8'd32;
  localparam logic [7:0] TURN_ZERO     = 8'd0;

  localparam logic [9:0] FWD_ORIGIN   = 10'd400;
  localparam logic [9:0] FWD_SLOPE    = 10'd30;
  localparam logic [9:0] REV_ORIGIN   = 10'd200;
  localparam logic [9:0] REV_SLOPE    = 10'd38;
  localparam logic [9:0] SPIN_COMPARE = 10'd1000;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] check_byte;
    logic [7:0] turn_axis;
    logic [7:0] speed_axis;
  } in_t;

  typedef struct packed {
    logic       drive_update;
    logic [9:0] left_compare;
    logic       left_level;
    logic [9:0] right_compare;
    logic       right_level;
    logic       radio_owner;
    logic       link_lost;
    logic       frame_error;
  } out_t;

  typedef struct packed {
    logic       owner_is_radio;
    logic [7:0] miss_counter;
  } state_t;

endpackage

FILE: rtl/core/jdm_mix.sv
module jdm_mix (
  input  logic [3:0] base,
  input  logic [7:0] turn,
  output logic [3:0] duty_left,
  output logic [3:0] duty_right
);

  logic       turn_left;
  logic       turn_right;
  logic [7:0] off;
  logic [8:0] gain_sum;
  logic [3:0] gain;
  logic [3:0] loss;

  assign turn_left  = turn >= jdm_pkg::TURN_LEFT_MIN;
  assign turn_right = turn <= jdm_pkg::DUTY_MAX;

  always_comb begin
    if (turn_left) begin
      off = turn - jdm_pkg::TURN_LEFT_MIN;
    end else if (turn_right) begin
      off = jdm_pkg::DUTY_MAX - turn;
    end else begin
      off = 8'd0;
    end
  end

  assign gain_sum = {5'b0, base} + {1'b0, off};
  assign gain     = (gain_sum > {1'b0, jdm_pkg::DUTY_MAX}) ? 4'(jdm_pkg::DUTY_MAX)
                                                         : gain_sum[3:0];
  assign loss     = (off >= {4'b0, base}) ? 4'd0 : base - off[3:0];

  always_comb begin
    if (turn_left) begin
      duty_left  = gain;
      duty_right = loss;
    end else if (turn_right) begin
      duty_left  = loss;
      duty_right = gain;
    end else begin
      duty_left  = base;
      duty_right = base;
    end
  end

endmodule

FILE: rtl/core/jdm_step.sv
module jdm_step (
  input  jdm_pkg::in_t    item,
  input  jdm_pkg::state_t state,
  input  logic [7:0]      loss_threshold,
  input  logic [7:0]      loss_reload,
  output jdm_pkg::out_t   result,
  output jdm_pkg::state_t state_nxt
);

  logic [7:0] speed_sat;
  logic       frame_bad;
  logic       fwd;
  logic       rev;
  logic       turn_neutral;
  logic [3:0] base;
  logic [3:0] duty_left;
  logic [3:0] duty_right;
  logic [9:0] fwd_left;
  logic [9:0] fwd_right;
  logic [9:0] rev_left;
  logic [9:0] rev_right;

  assign speed_sat = (item.speed_axis > jdm_pkg::SPEED_CAP) ? jdm_pkg::SPEED_CAP
                                                             : item.speed_axis;
  assign frame_bad = (item.check_byte == item.turn_axis) && (speed_sat == item.turn_axis)
                     && (item.speed_axis == item.turn_axis);
  assign fwd = speed_sat <= jdm_pkg::DUTY_MAX;
  assign rev = speed_sat >= jdm_pkg::TURN_LEFT_MIN;
  assign turn_neutral = (item.turn_axis > jdm_pkg::DUTY_MAX)
                        && (item.turn_axis < jdm_pkg::TURN_LEFT_MIN);
  assign base = fwd ? 4'(jdm_pkg::DUTY_MAX - speed_sat)
                    : 4'(speed_sat - jdm_pkg::TURN_LEFT_MIN);

  jdm_mix u_mix (
    .base       (base),
    .turn       (item.turn_axis),
    .duty_left  (duty_left),
    .duty_right (duty_right)
  );

  assign fwd_left  = jdm_pkg::FWD_ORIGIN - jdm_pkg::FWD_SLOPE * {6'b0, duty_left};
  assign fwd_right = jdm_pkg::FWD_ORIGIN - jdm_pkg::FWD_SLOPE * {6'b0, duty_right};
  assign rev_left  = jdm_pkg::REV_ORIGIN + jdm_pkg::REV_SLOPE * {6'b0, duty_left};
  assign rev_right = jdm_pkg::REV_ORIGIN + jdm_pkg::REV_SLOPE * {6'b0, duty_right};

  always_comb begin
    result    = '0;
    state_nxt = state;
    unique case (item.command)
      jdm_pkg::CMD_PACKET: begin
        state_nxt.miss_counter = 8'd0;
        if (frame_bad) begin
          result.frame_error = 1'b1;
        end else if (fwd) begin
          state_nxt.owner_is_radio = 1'b1;
          result.drive_update  = 1'b1;
          result.left_compare  = fwd_left;
          result.left_level    = 1'b1;
          result.right_compare = fwd_right;
          result.right_level   = 1'b1;
        end else if (rev) begin
          result.drive_update  = 1'b1;
          result.left_compare  = rev_left;
          result.right_compare = rev_right;
        end else if (item.turn_axis == jdm_pkg::SPEED_CAP) begin
          result.drive_update  = 1'b1;
          result.left_level    = 1'b1;
          result.right_compare = jdm_pkg::SPIN_COMPARE;
        end else if (item.turn_axis == jdm_pkg::TURN_ZERO) begin
          result.drive_update  = 1'b1;
          result.left_compare  = jdm_pkg::SPIN_COMPARE;
          result.right_level   = 1'b1;
        end else if (turn_neutral && state.owner_is_radio) begin
          result.drive_update = 1'b1;
        end
      end
      jdm_pkg::CMD_POLL: begin
        if (state.owner_is_radio && (state.miss_counter > loss_threshold)) begin
          state_nxt.miss_counter   = loss_reload;
          state_nxt.owner_is_radio = 1'b0;
          result.link_lost    = 1'b1;
          result.drive_update = 1'b1;
        end else begin
          state_nxt.miss_counter = state.miss_counter + 8'd1;
        end
      end
      jdm_pkg::CMD_SERIAL: begin
        state_nxt.owner_is_radio = 1'b0;
      end
      default: begin
        state_nxt = state;
      end
    endcase
    result.radio_owner = state_nxt.owner_is_radio;
  end

endmodule

FILE: rtl/core/joystick_diff_drive_mixer.sv
// Arcade mixer for a two-motor drive: each word is a radio packet, a poll that found no
// packet or a serial takeover, and each gives exactly one result word with motor compare
// values, direction levels, ownership and status. Words pass through an input register and
// a result register with the whole mixing step between them, so one word is taken every
// cycle while the output is not stalled, and each result is held in the result register until
// the output takes it.
// The loss threshold and reload registers should be written only while the block is idle.
module joystick_diff_drive_mixer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jdm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jdm_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_wdata
);

  logic            s1_valid_r;
  jdm_pkg::in_t    s1_data_r;
  logic            out_valid_r;
  jdm_pkg::out_t   out_data_r;
  jdm_pkg::state_t state_r;
  jdm_pkg::state_t state_nxt;
  jdm_pkg::out_t   result;
  logic [7:0]      loss_threshold_r;
  logic [7:0]      loss_reload_r;
  logic            advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  jdm_step u_step (
    .item           (s1_data_r),
    .state          (state_r),
    .loss_threshold (loss_threshold_r),
    .loss_reload    (loss_reload_r),
    .result         (result),
    .state_nxt      (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      state_r          <= '0;
      loss_threshold_r <= jdm_pkg::LOSS_THRESHOLD_RESET;
      loss_reload_r    <= jdm_pkg::LOSS_RELOAD_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          jdm_pkg::REG_LOSS_THRESHOLD: loss_threshold_r <= cfg_wdata;
          jdm_pkg::REG_LOSS_RELOAD:    loss_reload_r    <= cfg_wdata;
          default:                     loss_reload_r    <= loss_reload_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  a_lost_hands_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.link_lost |-> !out_data_r.radio_owner && out_data_r.drive_update)
    else $error("link loss reported while radio still owns control");

  a_error_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_error |-> !out_data_r.drive_update)
    else $error("rejected frame produced a motor update");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.drive_update |->
      out_data_r.left_compare == 10'd0 && out_data_r.right_compare == 10'd0
      && !out_data_r.left_level && !out_data_r.right_level)
    else $error("motor fields set without an update");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_state_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance) && $past(rst_n) |-> $stable(state_r))
    else $error("control state changed without a word advancing");

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 50;

  typedef struct {
    jdm_pkg::in_t  word;
    int            reps;
    bit            typed;
    jdm_pkg::out_t result;
  } step_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  jdm_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  jdm_pkg::out_t out_data;
  logic          cfg_wr_en;
  logic          cfg_index;
  logic [7:0]    cfg_wdata;

  logic [7:0] loss_thr = jdm_pkg::LOSS_THRESHOLD_RESET;
  logic [7:0] loss_rel = jdm_pkg::LOSS_RELOAD_RESET;
  logic       owner_radio = 1'b0;
  logic [7:0] miss_count = 8'd0;

  jdm_pkg::out_t pending_drive[$];
  bit            cur_typed;
  jdm_pkg::out_t cur_expect;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_request = 0;
  int   poll_run = 0;
  int   errors = 0;
  int   words_in = 0;
  int   results_out = 0;
  int   updates_seen = 0;
  int   losses_seen = 0;
  int   frame_errors_seen = 0;
  int   cycle_count = 0;

  joystick_diff_drive_mixer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void mix_duty(input int base, input int trn, output int d1, output int d2);
    int off;
    if (trn >= int'(jdm_pkg::TURN_LEFT_MIN)) begin
      off = trn - int'(jdm_pkg::TURN_LEFT_MIN);
      d1 = (base + off > int'(jdm_pkg::DUTY_MAX)) ? int'(jdm_pkg::DUTY_MAX) : base + off;
      d2 = (off >= base) ? 0 : base - off;
    end else if (trn <= int'(jdm_pkg::DUTY_MAX)) begin
      off = int'(jdm_pkg::DUTY_MAX) - trn;
      d2 = (base + off > int'(jdm_pkg::DUTY_MAX)) ? int'(jdm_pkg::DUTY_MAX) : base + off;
      d1 = (off >= base) ? 0 : base - off;
    end else begin
      d1 = base;
      d2 = base;
    end
  endfunction

  function automatic jdm_pkg::out_t predict_drive(input jdm_pkg::in_t w);
    jdm_pkg::out_t r;
    int   spd;
    int   trn;
    int   d1;
    int   d2;
    r = '0;
    spd = (w.speed_axis > jdm_pkg::SPEED_CAP) ? int'(jdm_pkg::SPEED_CAP) : int'(w.speed_axis);
    trn = int'(w.turn_axis);
    case (w.command)
      jdm_pkg::CMD_PACKET: begin
        miss_count = 8'd0;
        if (w.check_byte == w.turn_axis && spd == trn && w.speed_axis == w.turn_axis) begin
          r.frame_error = 1'b1;
        end else if (spd <= int'(jdm_pkg::DUTY_MAX)) begin
          owner_radio = 1'b1;
          mix_duty(int'(jdm_pkg::DUTY_MAX) - spd, trn, d1, d2);
          r.drive_update = 1'b1;
          r.left_compare = 10'(int'(jdm_pkg::FWD_ORIGIN) - int'(jdm_pkg::FWD_SLOPE) * d1);
          r.left_level = 1'b1;
          r.right_compare = 10'(int'(jdm_pkg::FWD_ORIGIN) - int'(jdm_pkg::FWD_SLOPE) * d2);
          r.right_level = 1'b1;
        end else if (spd >= int'(jdm_pkg::TURN_LEFT_MIN)) begin
          mix_duty(spd - int'(jdm_pkg::TURN_LEFT_MIN), trn, d1, d2);
          r.drive_update = 1'b1;
          r.left_compare = 10'(int'(jdm_pkg::REV_ORIGIN) + int'(jdm_pkg::REV_SLOPE) * d1);
          r.right_compare = 10'(int'(jdm_pkg::REV_ORIGIN) + int'(jdm_pkg::REV_SLOPE) * d2);
        end else if (trn == int'(jdm_pkg::SPEED_CAP)) begin
          r.drive_update = 1'b1;
          r.left_level = 1'b1;
          r.right_compare = jdm_pkg::SPIN_COMPARE;
        end else if (trn == int'(jdm_pkg::TURN_ZERO)) begin
          r.drive_update = 1'b1;
          r.left_compare = jdm_pkg::SPIN_COMPARE;
          r.right_level = 1'b1;
        end else if (trn > int'(jdm_pkg::DUTY_MAX) && trn < int'(jdm_pkg::TURN_LEFT_MIN)
                     && owner_radio) begin
          r.drive_update = 1'b1;
        end
      end
      jdm_pkg::CMD_POLL: begin
        if (owner_radio && miss_count > loss_thr) begin
          miss_count = loss_rel;
          owner_radio = 1'b0;
          r.link_lost = 1'b1;
          r.drive_update = 1'b1;
        end else begin
          miss_count = miss_count + 8'd1;
        end
      end
      jdm_pkg::CMD_SERIAL: owner_radio = 1'b0;
      default: ;
    endcase
    r.radio_owner = owner_radio;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (errors < PRINT_LIMIT)
      $display("%0t: %s wrong on result %0d: got %0d, wanted %0d",
               $time, field, results_out, got, want);
    errors++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin
    jdm_pkg::out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_drive.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_drive.size() == 0) begin
          report_mismatch("unexpected word, frame_error", int'(out_data.frame_error), 0);
        end else begin
          want = pending_drive.pop_front();
          check_field("drive_update", int'(out_data.drive_update), int'(want.drive_update));
          check_field("left_compare", int'(out_data.left_compare), int'(want.left_compare));
          check_field("left_level", int'(out_data.left_level), int'(want.left_level));
          check_field("right_compare", int'(out_data.right_compare),
                      int'(want.right_compare));
          check_field("right_level", int'(out_data.right_level), int'(want.right_level));
          check_field("radio_owner", int'(out_data.radio_owner), int'(want.radio_owner));
          check_field("link_lost", int'(out_data.link_lost), int'(want.link_lost));
          check_field("frame_error", int'(out_data.frame_error), int'(want.frame_error));
        end
        results_out++;
        updates_seen += int'(out_data.drive_update);
        losses_seen += int'(out_data.link_lost);
        frame_errors_seen += int'(out_data.frame_error);
      end
      if (in_valid && in_ready) begin
        want = predict_drive(in_data);
        pending_drive.push_back(cur_typed ? cur_expect : want);
        words_in++;
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic jdm_pkg::in_t random_word();
    jdm_pkg::in_t w;
    int  pick;
    w = jdm_pkg::in_t'(26'($urandom));
    w.command = jdm_pkg::CMD_PACKET;
    if (poll_run > 0) begin
      poll_run--;
      w.command = jdm_pkg::CMD_POLL;
      return w;
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.turn_axis = 8'($urandom_range(0, 32));
      w.speed_axis = 8'($urandom_range(0, 32));
      if ($urandom_range(0, 15) == 0) begin
        w.turn_axis = w.speed_axis;
        w.check_byte = w.speed_axis;
      end
    end else if (pick < 55) begin
      if ($urandom_range(0, 7) == 0) begin
        w.turn_axis = w.check_byte;
        w.speed_axis = w.check_byte;
      end
    end else if (pick < 60) begin
      w.command = jdm_pkg::CMD_POLL;
      poll_run = (loss_thr > 8'd40) ? $urandom_range(1, 40) : loss_thr + $urandom_range(1, 4);
    end else if (pick < 85) begin
      w.command = jdm_pkg::CMD_POLL;
    end else if (pick < 95) begin
      w.command = jdm_pkg::CMD_SERIAL;
    end else begin
      w.command = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input jdm_pkg::in_t w, input bit typed, input jdm_pkg::out_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data <= jdm_pkg::in_t'(26'($urandom));
      @(negedge clk);
    end
    cur_typed = typed;
    cur_expect = res;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [7:0] thr, input logic [7:0] rel);
    cfg_wr_en <= 1'b1;
    cfg_index <= jdm_pkg::REG_LOSS_THRESHOLD;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_index <= jdm_pkg::REG_LOSS_RELOAD;
    cfg_wdata <= rel;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    loss_thr = thr;
    loss_rel = rel;
  endtask

  task automatic run_phase(input logic [7:0] thr, input logic [7:0] rel, input int idle,
                           input int stall, input int hold, input int count);
    int           sent;
    jdm_pkg::in_t w;
    sent = 0;
    wait_idle();
    write_regs(thr, rel);
    send_idle_pct = idle;
    stall_pct = stall;
    if (hold > 0) begin
      @(posedge clk);
      hold_request = hold;
      @(negedge clk);
    end
    while (sent < count) begin
      w = random_word();
      send_word(w, 1'b0, '0);
      if (w.command != CMD_UNUSED) sent++;
    end
  endtask

  function automatic step_t mk_step(input logic [1:0] cmd, input logic [7:0] chk,
                                    input logic [7:0] trn, input logic [7:0] spd,
                                    input int reps, input bit typed,
                                    input jdm_pkg::out_t res);
    step_t s;
    s.word = '{cmd, chk, trn, spd};
    s.reps = reps;
    s.typed = typed;
    s.result = res;
    return s;
  endfunction

  initial begin
    step_t directed[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = jdm_pkg::REG_LOSS_THRESHOLD;
    cfg_wdata = '0;
    cur_typed = 1'b0;
    cur_expect = '0;

    directed.push_back(mk_step(jdm_pkg::CMD_SERIAL, 8'd0, 8'd0, 8'd0, 1, 1, '0));
    directed.push_back(mk_step(CMD_UNUSED, 8'hAA, 8'h55, 8'hFF, 1, 1, '0));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd7, 8'd7, 8'd7, 1, 1,
      jdm_pkg::out_t'{1'b0, 10'd0, 1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd0, 8'd16, 8'd0, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd10, 1'b1, 10'd10, 1'b1, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd0, 8'd16, 8'd13, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd400, 1'b1, 10'd400, 1'b1, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd1, 8'd16, 8'd255, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd694, 1'b0, 10'd694, 1'b0, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd0, 8'd16, 8'd16, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd0, 1'b0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd0, 8'd32, 8'd16, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd0, 1'b1, 10'd1000, 1'b0, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd1, 8'd0, 8'd16, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd1000, 1'b0, 10'd0, 1'b1, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd0, 8'd255, 8'd0, 1, 0, '0));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd255, 8'd255, 8'd255, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd694, 1'b0, 10'd200, 1'b0, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_PACKET, 8'd0, 8'd20, 8'd16, 1, 0, '0));
    directed.push_back(mk_step(jdm_pkg::CMD_POLL, 8'd0, 8'd0, 8'd0, 12, 1,
      jdm_pkg::out_t'{1'b0, 10'd0, 1'b0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_POLL, 8'd0, 8'd0, 8'd0, 1, 1,
      jdm_pkg::out_t'{1'b1, 10'd0, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0}));
    directed.push_back(mk_step(jdm_pkg::CMD_POLL, 8'd0, 8'd0, 8'd0, 1, 1, '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      repeat (directed[i].reps) send_word(directed[i].word, directed[i].typed, directed[i].result);

    run_phase(jdm_pkg::LOSS_THRESHOLD_RESET, jdm_pkg::LOSS_RELOAD_RESET, 0, 0, 0, 255);
    run_phase(8'd0, 8'd0, 46, 0, 0, 255);
    run_phase(8'd255, 8'd255, 0, 46, 0, 255);
    run_phase(8'd3, 8'd200, 38, 38, 0, 255);
    run_phase(8'($urandom_range(0, 30)), 8'($urandom), 0, 0, 300, 255);

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Covered %0d words and %0d results over five threshold settings and stall mixes.",
             words_in, results_out);
    $display("Saw %0d motor updates, %0d link losses and %0d rejected frames.",
             updates_seen, losses_seen, frame_errors_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field errors found.", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/jdm_pkg.sv
rtl/core/jdm_mix.sv
rtl/core/jdm_step.sv
rtl/core/joystick_diff_drive_mixer.sv
tb/tb.sv
